@@ rtl/lwrt_pkg.sv @@
// Shared types, constants and helper functions for the latency window
// resend timeout block. No dependencies.
`timescale 1ns / 1ps

package lwrt_pkg;

    // Window and top-set sizing
    localparam int WINDOW_DEPTH = 16;
    localparam int TOP_COUNT    = 4;

    localparam int STAMP_W   = 16;
    localparam int TIMEOUT_W = 8;
    localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int TOP_IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    localparam logic [STAMP_W-1:0]   LATENCY_MAX  = 16'd65000;
    localparam logic [STAMP_W-1:0]   QUERY_STAMP  = 16'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_CAP  = 8'd200;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_STEP = 8'd33;
    localparam int TIMEOUT_STEPS = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lwrt_state_t;

    // Ring access for one cycle
    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_addr;
        logic [STAMP_W-1:0] wr_data;
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
    } ring_req_t;

    // Top-set control
    typedef struct packed {
        logic               clear;
        logic               load;
        logic [STAMP_W-1:0] value;
    } topset_ctrl_t;

    // Top-set status
    typedef struct packed {
        logic               empty;
        logic [STAMP_W-1:0] minimum;
    } topset_status_t;

    // Clamp to the cap, then floor to a multiple of the step
    function automatic logic [TIMEOUT_W-1:0] timeout_of(input logic [STAMP_W-1:0] value);
        logic [TIMEOUT_W-1:0] clamped;
        logic [TIMEOUT_W-1:0] result;
        logic [TIMEOUT_W-1:0] mult;
        clamped = (value > STAMP_W'(TIMEOUT_CAP)) ? TIMEOUT_CAP : value[TIMEOUT_W-1:0];
        result  = '0;
        mult    = '0;
        for (int k = 1; k <= TIMEOUT_STEPS; k++)
        begin
            mult = mult + TIMEOUT_STEP;
            if (clamped >= mult)
                result = mult;
        end
        return result;
    endfunction

endpackage

@@ rtl/lwrt_ring.sv @@
// Sample ring storage: one write port, one registered read port.
// Depends on lwrt_pkg.
`timescale 1ns / 1ps

module lwrt_ring (
    input  logic                               clk,
    input  lwrt_pkg::ring_req_t                req,
    output logic [lwrt_pkg::STAMP_W-1:0]       rd_data
);

    logic [lwrt_pkg::STAMP_W-1:0] mem [lwrt_pkg::WINDOW_DEPTH];

    // Write a new sample
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data <= mem[req.rd_addr];
    end

endmodule

@@ rtl/lwrt_topset.sv @@
// Distinct top-value set: takes one sample per cycle, keeps the largest
// distinct values and reports the set minimum. Depends on lwrt_pkg.
`timescale 1ns / 1ps

module lwrt_topset (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lwrt_pkg::topset_ctrl_t   ctrl,
    output lwrt_pkg::topset_status_t status
);

    logic [lwrt_pkg::STAMP_W-1:0]   val_reg  [lwrt_pkg::TOP_COUNT];
    logic [lwrt_pkg::STAMP_W-1:0]   val_next [lwrt_pkg::TOP_COUNT];
    logic [lwrt_pkg::TOP_COUNT-1:0] vld_reg;
    logic [lwrt_pkg::TOP_COUNT-1:0] vld_next;

    logic [lwrt_pkg::TOP_COUNT-1:0] match;
    logic                           full;
    logic [lwrt_pkg::TOP_IDX_W-1:0] min_idx;
    logic [lwrt_pkg::TOP_IDX_W-1:0] free_idx;
    logic                           free_found;
    logic [lwrt_pkg::STAMP_W-1:0]   min_val;
    logic                           min_found;

    // Compare the incoming value against every entry; locate min and free slot
    always_comb
    begin
        full       = &vld_reg;
        min_idx    = '0;
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < lwrt_pkg::TOP_COUNT; i++)
        begin
            match[i] = vld_reg[i] && (val_reg[i] == ctrl.value);
            if (!vld_reg[i] && !free_found)
            begin
                free_idx   = lwrt_pkg::TOP_IDX_W'(i);
                free_found = 1'b1;
            end
            if (val_reg[i] < val_reg[min_idx])
                min_idx = lwrt_pkg::TOP_IDX_W'(i);
        end
    end

    // Insert, evict or clear
    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.clear)
        begin
            vld_next = '0;
        end
        else if (ctrl.load)
        begin
            if (!full)
            begin
                if (!(|match))
                begin
                    val_next[free_idx] = ctrl.value;
                    vld_next[free_idx] = 1'b1;
                end
            end
            else if (ctrl.value > val_reg[min_idx])
            begin
                // Evict the minimum; reuse its slot unless the value is a duplicate
                if (|match)
                    vld_next[min_idx] = 1'b0;
                else
                    val_next[min_idx] = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // Minimum over the valid entries
    always_comb
    begin
        min_val   = '0;
        min_found = 1'b0;
        for (int i = 0; i < lwrt_pkg::TOP_COUNT; i++)
        begin
            if (vld_reg[i] && (!min_found || val_reg[i] < min_val))
            begin
                min_val   = val_reg[i];
                min_found = 1'b1;
            end
        end
        status.empty   = !min_found;
        status.minimum = min_val;
    end

endmodule

@@ rtl/latency_window_resend_timeout_top.sv @@
// Top level of the latency window resend timeout block: handshakes, scan
// sequencer, ring and top-set. Depends on lwrt_pkg, lwrt_ring, lwrt_topset.
//
//  Channel  Dir  Signals                   Content
//  s_*      in   tvalid tready tdata[31:0] now_stamp, send_stamp
//  m_*      out  tvalid tready tdata[23:0] resend_timeout, window_value
//                tuser[1:0]                no_data, sample_taken
//
// Each item is accepted (its sample stored if kept), then every filled slot is
// read from the ring in turn, the last read is loaded into the top-set, the read
// pipeline drains and the finish state loads the result; an empty window skips the reads.
// The scan is bound by the single ring read port and the one-value-per-cycle top-set.
// s_tready is low from acceptance until the result is loaded into the output
// register; a result waiting on m_tready holds the block only at finish.
// Reset clears the window counts; ring contents are only read once written.
`timescale 1ns / 1ps

module latency_window_resend_timeout_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] now_stamp, [31:16] send_stamp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] resend_timeout, [23:8] window_value
    output logic [1:0]  m_tuser    // [0] no_data, [1] sample_taken
);

    lwrt_pkg::lwrt_state_t state_reg, state_next;

    logic [lwrt_pkg::SLOT_W-1:0]    write_slot_reg, write_slot_next;
    logic [lwrt_pkg::CNT_W-1:0]     filled_count_reg, filled_count_next;
    logic [lwrt_pkg::CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                           pend_reg, pend_next;
    logic                           taken_reg, taken_next;
    logic                           out_valid_reg, out_valid_next;
    logic [lwrt_pkg::TIMEOUT_W-1:0] out_timeout_reg, out_timeout_next;
    logic [lwrt_pkg::STAMP_W-1:0]   out_window_reg, out_window_next;
    logic                           out_empty_reg, out_empty_next;
    logic                           out_taken_reg, out_taken_next;

    logic [lwrt_pkg::STAMP_W-1:0] now_stamp;
    logic [lwrt_pkg::STAMP_W-1:0] send_stamp;
    logic [lwrt_pkg::STAMP_W-1:0] latency;
    logic                         accept;
    logic                         store;
    logic                         issue_en;

    lwrt_pkg::ring_req_t          ring_req;
    logic [lwrt_pkg::STAMP_W-1:0] ring_rd_data;
    lwrt_pkg::topset_ctrl_t       set_ctrl;
    lwrt_pkg::topset_status_t     set_status;

    assign now_stamp  = s_tdata[15:0];
    assign send_stamp = s_tdata[31:16];
    assign latency    = now_stamp - send_stamp;
    assign s_tready   = (state_reg == lwrt_pkg::ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign store      = accept && (send_stamp != lwrt_pkg::QUERY_STAMP)
                        && (latency <= lwrt_pkg::LATENCY_MAX);
    assign issue_en   = (state_reg == lwrt_pkg::ST_SCAN) && (issue_idx_reg < filled_count_reg);

    // Ring port: store a kept sample on acceptance, read one slot a cycle during the scan
    always_comb
    begin
        ring_req.wr_en   = store;
        ring_req.wr_addr = write_slot_reg;
        ring_req.wr_data = latency;
        ring_req.rd_en   = issue_en;
        ring_req.rd_addr = issue_idx_reg[lwrt_pkg::SLOT_W-1:0];
    end

    // Top-set feed: clear on acceptance, take each returned sample
    always_comb
    begin
        set_ctrl.clear = accept;
        set_ctrl.load  = pend_reg;
        set_ctrl.value = ring_rd_data;
    end

    lwrt_ring u_ring (
        .clk     (clk),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    lwrt_topset u_topset (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (set_ctrl),
        .status (set_status)
    );

    // Sequencer and output register
    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        filled_count_next = filled_count_reg;
        issue_idx_next    = issue_idx_reg;
        pend_next         = issue_en;
        taken_next        = taken_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_timeout_next  = out_timeout_reg;
        out_window_next   = out_window_reg;
        out_empty_next    = out_empty_reg;
        out_taken_next    = out_taken_reg;

        unique case (state_reg)
            lwrt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    taken_next     = store;
                    issue_idx_next = '0;
                    state_next     = lwrt_pkg::ST_SCAN;
                    if (store)
                    begin
                        if (write_slot_reg == lwrt_pkg::SLOT_W'(lwrt_pkg::WINDOW_DEPTH - 1))
                            write_slot_next = '0;
                        else
                            write_slot_next = write_slot_reg + 1'b1;
                        if (filled_count_reg != lwrt_pkg::CNT_W'(lwrt_pkg::WINDOW_DEPTH))
                            filled_count_next = filled_count_reg + 1'b1;
                    end
                end
            end
            lwrt_pkg::ST_SCAN:
            begin
                if (issue_en)
                    issue_idx_next = issue_idx_reg + 1'b1;
                else if (!pend_reg)
                    state_next = lwrt_pkg::ST_FINISH;
            end
            lwrt_pkg::ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_empty_next   = set_status.empty;
                    out_taken_next   = taken_reg;
                    out_window_next  = set_status.empty ? '0 : set_status.minimum;
                    out_timeout_next = set_status.empty
                                       ? lwrt_pkg::timeout_of(lwrt_pkg::STAMP_W'(lwrt_pkg::TIMEOUT_CAP))
                                       : lwrt_pkg::timeout_of(set_status.minimum);
                    state_next       = lwrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lwrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lwrt_pkg::ST_IDLE;
            write_slot_reg   <= '0;
            filled_count_reg <= '0;
            issue_idx_reg    <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_slot_reg   <= write_slot_next;
            filled_count_reg <= filled_count_next;
            issue_idx_reg    <= issue_idx_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg       <= taken_next;
        out_timeout_reg <= out_timeout_next;
        out_window_reg  <= out_window_next;
        out_empty_reg   <= out_empty_next;
        out_taken_reg   <= out_taken_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_window_reg, out_timeout_reg};
    assign m_tuser  = {out_taken_reg, out_empty_reg};

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("block took a second transfer before finishing the first");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_count_reg <= lwrt_pkg::CNT_W'(lwrt_pkg::WINDOW_DEPTH))
        else $error("filled count beyond window depth");

    a_taken_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("sample stored but window reported empty");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[23:8] == 16'd0) && (m_tdata[7:0] == 8'd198))
        else $error("empty window result carries wrong values");

endmodule

@@ bench/latency_window_resend_timeout_top_test.sv @@
// Testbench for latency_window_resend_timeout_top: random bursts of time stamps
// go in; a scoreboard predicts every result. Depends on lwrt_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [lwrt_pkg::TIMEOUT_W-1:0] resend_timeout;
    logic [lwrt_pkg::STAMP_W-1:0]   window_value;
    logic                           no_data;
    logic                           sample_taken;
} timeout_result_t;

// Track the latency ring and predict the timeout for each accepted transfer
class timeout_scoreboard;
    logic [lwrt_pkg::STAMP_W-1:0] latency_ring [lwrt_pkg::WINDOW_DEPTH];
    int unsigned                  next_slot;
    int unsigned                  slots_filled;
    timeout_result_t              expected_timeouts [$];
    int                           errors;

    function new();
        next_slot    = 0;
        slots_filled = 0;
        errors       = 0;
    endfunction

    // Scan filled slots in slot order through the distinct top set; return its minimum
    function void top_set_floor(output bit empty, output logic [lwrt_pkg::STAMP_W-1:0] floor_val);
        logic [lwrt_pkg::STAMP_W-1:0] top_set [lwrt_pkg::TOP_COUNT];
        logic [lwrt_pkg::STAMP_W-1:0] v;
        int                           count;
        int                           mi;
        bit                           present;
        count = 0;
        for (int i = 0; i < slots_filled; i++)
        begin
            v       = latency_ring[i];
            present = 0;
            if (count < lwrt_pkg::TOP_COUNT)
            begin
                for (int j = 0; j < count; j++)
                    if (top_set[j] == v)
                        present = 1;
                if (!present)
                begin
                    top_set[count] = v;
                    count++;
                end
            end
            else
            begin
                mi = 0;
                for (int j = 1; j < count; j++)
                    if (top_set[j] < top_set[mi])
                        mi = j;
                // Evict the minimum; a duplicate then leaves the set one smaller
                if (v > top_set[mi])
                begin
                    for (int k = mi; k + 1 < count; k++)
                        top_set[k] = top_set[k + 1];
                    count--;
                    for (int j = 0; j < count; j++)
                        if (top_set[j] == v)
                            present = 1;
                    if (!present)
                    begin
                        top_set[count] = v;
                        count++;
                    end
                end
            end
        end
        empty     = (count == 0);
        floor_val = '0;
        if (!empty)
        begin
            floor_val = top_set[0];
            for (int j = 1; j < count; j++)
                if (top_set[j] < floor_val)
                    floor_val = top_set[j];
        end
    endfunction

    // Update the ring for one accepted input transfer and queue its result
    function void note_item(input logic [lwrt_pkg::STAMP_W-1:0] now,
                            input logic [lwrt_pkg::STAMP_W-1:0] sent);
        logic [lwrt_pkg::STAMP_W-1:0] lat;
        logic [lwrt_pkg::STAMP_W-1:0] floor_val;
        bit                           empty;
        int                           clamped;
        timeout_result_t              res;
        res.sample_taken = 1'b0;
        if (sent != lwrt_pkg::QUERY_STAMP)
        begin
            lat = now - sent;
            if (lat <= lwrt_pkg::LATENCY_MAX)
            begin
                latency_ring[next_slot] = lat;
                next_slot = (next_slot + 1) % lwrt_pkg::WINDOW_DEPTH;
                if (slots_filled < lwrt_pkg::WINDOW_DEPTH)
                    slots_filled++;
                res.sample_taken = 1'b1;
            end
        end
        top_set_floor(empty, floor_val);
        clamped = (empty || floor_val > lwrt_pkg::TIMEOUT_CAP)
                  ? int'(lwrt_pkg::TIMEOUT_CAP) : int'(floor_val);
        res.resend_timeout = lwrt_pkg::TIMEOUT_W'((clamped / int'(lwrt_pkg::TIMEOUT_STEP))
                                                  * int'(lwrt_pkg::TIMEOUT_STEP));
        res.window_value   = floor_val;
        res.no_data        = empty;
        expected_timeouts  = {expected_timeouts, res};
    endfunction

    function void report(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
        errors++;
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_result(input logic [23:0] data, input logic [1:0] user);
        timeout_result_t exp_res;
        if (expected_timeouts.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                     $time, data, user);
            errors++;
            return;
        end
        exp_res = expected_timeouts.pop_front();
        if (data[7:0] !== exp_res.resend_timeout)
            report("resend_timeout", exp_res.resend_timeout, data[7:0]);
        if (data[23:8] !== exp_res.window_value)
            report("window_value", exp_res.window_value, data[23:8]);
        if (user[0] !== exp_res.no_data)
            report("no_data", exp_res.no_data, user[0]);
        if (user[1] !== exp_res.sample_taken)
            report("sample_taken", exp_res.sample_taken, user[1]);
    endfunction

    function int pending();
        return expected_timeouts.size();
    endfunction
endclass

module latency_window_resend_timeout_top_test;

    localparam int RANDOM_ITEMS = 1450;
    localparam int LONG_HOLD    = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] now_stamp, [31:16] send_stamp
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] resend_timeout, [23:8] window_value
    logic [1:0]  m_tuser;   // [0] no_data, [1] sample_taken

    timeout_scoreboard sb;
    int                items_accepted;
    int                burst_left;

    // Latencies that walk the timeout steps, force a duplicate while full and wrap the ring
    int unsigned directed_lats [16] = '{200, 199, 33, 32, 200, 66, 99, 132, 165,
                                        10, 10, 300, 34, 1000, 198, 231};

    latency_window_resend_timeout_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one transfer, wait for acceptance, then maybe idle between bursts
    task automatic offer(input logic [lwrt_pkg::STAMP_W-1:0] now,
                         input logic [lwrt_pkg::STAMP_W-1:0] sent);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {sent, now};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(now, sent);
        items_accepted++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Offer a sample with the given latency at a random local time
    task automatic offer_latency(input logic [lwrt_pkg::STAMP_W-1:0] lat);
        logic [lwrt_pkg::STAMP_W-1:0] now;
        logic [lwrt_pkg::STAMP_W-1:0] sent;
        now  = lwrt_pkg::STAMP_W'($urandom);
        sent = now - lat;
        if (sent == lwrt_pkg::QUERY_STAMP)
        begin
            now++;
            sent++;
        end
        offer(now, sent);
    endtask

    // Receiver: stall in changing patterns, with one long hold-off
    initial
    begin : receiver
        int  mode;
        int  len;
        bit  long_hold_done;
        long_hold_done = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && items_accepted >= 120)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            for (int n = 0; n < len; n++)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= (n % 5 == 0);
                    default: m_tready <= ($urandom_range(0, 1) == 1);
                endcase
                @(posedge clk);
            end
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int pick;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        items_accepted = 0;
        burst_left     = 4;
        sb             = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Query on an empty window, then latency extremes around the drop limit
        offer(16'd100, lwrt_pkg::QUERY_STAMP);
        offer(16'h0000, 16'h0001);
        offer(16'h0000, 16'd536);
        offer(16'h0000, 16'd535);
        offer(16'hFFFF, 16'hFFFF);
        offer(16'hFFFF, 16'h0001);
        offer(16'h8000, 16'h7FFF);
        foreach (directed_lats[i])
            offer_latency(lwrt_pkg::STAMP_W'(directed_lats[i]));
        offer(16'hFFFF, lwrt_pkg::QUERY_STAMP);

        // Random mix: queries, dropped, small and repeated latencies, full range
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                offer(lwrt_pkg::STAMP_W'($urandom), lwrt_pkg::QUERY_STAMP);
            else if (pick < 15)
                offer_latency(lwrt_pkg::STAMP_W'($urandom_range(65001, 65535)));
            else if (pick < 50)
                offer_latency(lwrt_pkg::STAMP_W'($urandom_range(0, 260)));
            else if (pick < 70)
                offer_latency(lwrt_pkg::STAMP_W'($urandom_range(28, 40)));
            else if (pick < 85)
                offer_latency(lwrt_pkg::STAMP_W'($urandom_range(0, 65000)));
            else
                offer(lwrt_pkg::STAMP_W'($urandom), lwrt_pkg::STAMP_W'($urandom));
        end
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
